@@ design/tit_pkg.sv @@
// Shared types and constants for the time interval to ticks converter.
package tit_pkg;

    localparam int unsigned TICK_W         = 20;
    localparam int unsigned SEC_W          = 64;
    localparam int unsigned FRAC_W         = 30;
    localparam int unsigned TICKS_W        = 31;
    localparam int unsigned SECN_W         = 44;
    localparam int unsigned REM_W          = TICK_W + TICKS_W;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [TICK_W-1:0]  TICK_RESET   = 20'd10000;
    localparam logic [FRAC_W-1:0]  USEC_PER_SEC = 30'd1000000;
    localparam logic [FRAC_W-1:0]  NSEC_PER_USEC = 30'd1000;
    localparam logic [30:0]        RECIP_1000   = 31'd1099511628;
    localparam logic [SEC_W-1:0]   SEC_LIMIT    = 64'd9223372036854;
    localparam logic [SEC_W-1:0]   SEC_MAX      = {1'b0, {(SEC_W-1){1'b1}}};
    localparam logic [TICKS_W-1:0] TICKS_MAX    = {TICKS_W{1'b1}};

    typedef enum logic [1:0] {
        K_ZERO = 2'd0,
        K_SAT  = 2'd1,
        K_DIV  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [SECN_W-1:0]  sec;
        logic [FRAC_W-1:0]  usec;
    } t_job;

endpackage

@@ design/tit_front.sv @@
// Front end: accept intervals, round nanoseconds up to microseconds and classify.
module tit_front import tit_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [TICK_W-1:0] i_tick,
    input  logic              i_valid,
    input  logic              i_operation,
    input  logic [SEC_W-1:0]  i_seconds,
    input  logic [FRAC_W-1:0] i_fraction,
    output logic              o_push,
    output t_job              o_job
);

    logic              r1_valid, r2_valid;
    logic              r1_op;
    logic [SEC_W-1:0]  r1_sec;
    logic [FRAC_W-1:0] r1_frac;
    logic [20:0]       r1_q;
    t_job              r2_job;

    logic [60:0]       n_prod;
    logic [FRAC_W-1:0] n_q1000, n_usec, n_qinc;
    logic              n_rnd, n_carry, n_sat;
    logic [SEC_W-1:0]  n_sec;
    t_job              n_job;

    assign n_prod = {31'b0, i_fraction} * {30'b0, RECIP_1000};

    always_comb begin
        n_q1000 = FRAC_W'(r1_q) * NSEC_PER_USEC;
        n_rnd   = (n_q1000 != r1_frac);
        n_qinc  = FRAC_W'(r1_q) + FRAC_W'(n_rnd);
        n_carry = r1_op && n_rnd && (n_qinc >= USEC_PER_SEC);
        n_usec  = r1_op ? n_qinc : r1_frac;
        if (n_carry) begin
            n_usec = n_usec - USEC_PER_SEC;
        end
        n_sat = n_carry && (r1_sec == SEC_MAX);
        n_sec = r1_sec + SEC_W'(n_carry);
        n_job.sec  = n_sec[SECN_W-1:0];
        n_job.usec = n_usec;
        if (n_sat) begin
            n_job.kind = K_SAT;
        end else if (n_sec[SEC_W-1]) begin
            n_job.kind = K_ZERO;
        end else if (n_sec == '0 && n_usec == '0) begin
            n_job.kind = K_ZERO;
        end else if (n_sec > SEC_LIMIT || i_tick == '0) begin
            n_job.kind = K_SAT;
        end else begin
            n_job.kind = K_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op   <= i_operation;
            r1_sec  <= i_seconds;
            r1_frac <= i_fraction;
            r1_q    <= n_prod[60:40];
            r2_job  <= n_job;
        end
    end

    assign o_push = i_en && r2_valid;
    assign o_job  = r2_job;

endmodule

@@ design/tit_queue.sv @@
// Short queue between the front end and the divider pipeline.
module tit_queue import tit_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_empty,
    output logic o_full,
    output t_job o_job
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("queue underflow");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

@@ design/tit_back.sv @@
// Back end: scale to microseconds, check saturation, divide one bit per stage.
module tit_back import tit_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [TICK_W-1:0]  i_tick,
    input  logic               i_empty,
    input  t_job               i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [TICKS_W-1:0] o_ticks
);

    localparam int unsigned NST = TICKS_W;

    logic              en;
    logic              r1_v, r2_v;
    t_kind             r1_k, r2_k;
    logic [SEC_W-1:0]  r1_prod;
    logic [FRAC_W-1:0] r1_usec;
    logic [SEC_W-1:0]  r2_tot;
    logic [REM_W-1:0]  limit;

    logic               r_v [NST+1];
    t_kind              r_k [NST+1];
    logic [REM_W-1:0]   r_r [NST+1];
    logic [TICKS_W-1:0] r_q [NST+1];
    logic               n_v [NST+1];
    t_kind              n_k [NST+1];
    logic [REM_W-1:0]   n_r [NST+1];
    logic [TICKS_W-1:0] n_q [NST+1];
    logic [REM_W-1:0]   trial [NST];

    logic               r_ov;
    logic [TICKS_W-1:0] r_ot;
    logic [TICKS_W-1:0] n_ot;

    assign en    = !r_ov || !i_stall;
    assign o_pop = en && !i_empty;
    assign limit = {i_tick, {TICKS_W{1'b0}}} - REM_W'(i_tick);

    always_comb begin
        n_v[0] = r2_v;
        n_q[0] = '0;
        n_r[0] = r2_tot[REM_W-1:0];
        n_k[0] = r2_k;
        if (r2_k == K_DIV && r2_tot >= SEC_W'(limit)) begin
            n_k[0] = K_SAT;
        end
        for (int i = 0; i < NST; i++) begin
            trial[i]   = REM_W'(i_tick) << (NST - 1 - i);
            n_v[i+1]   = r_v[i];
            n_k[i+1]   = r_k[i];
            n_r[i+1]   = r_r[i];
            n_q[i+1]   = r_q[i];
            if (r_r[i] >= trial[i]) begin
                n_r[i+1] = r_r[i] - trial[i];
                n_q[i+1] = r_q[i] | (TICKS_W'(1) << (NST - 1 - i));
            end
        end
        case (r_k[NST])
            K_ZERO:  n_ot = '0;
            K_SAT:   n_ot = TICKS_MAX;
            default: n_ot = r_q[NST] + 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r_ov <= 1'b0;
            for (int i = 0; i <= NST; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (en) begin
            r1_v <= !i_empty;
            r2_v <= r1_v;
            r_ov <= r_v[NST];
            for (int i = 0; i <= NST; i++) begin
                r_v[i] <= n_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_k    <= i_job.kind;
            r1_prod <= SEC_W'(i_job.sec) * SEC_W'(USEC_PER_SEC);
            r1_usec <= i_job.usec;
            r2_k    <= r1_k;
            r2_tot  <= r1_prod + SEC_W'(r1_usec) + SEC_W'(i_tick) - 1'b1;
            r_ot    <= n_ot;
            for (int i = 0; i <= NST; i++) begin
                r_k[i] <= n_k[i];
                r_r[i] <= n_r[i];
                r_q[i] <= n_q[i];
            end
        end
    end

    assign o_valid = r_ov;
    assign o_ticks = r_ot;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> (r_ov && $stable(r_ot))) else $error("result lost");
    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NST] && r_k[NST] == K_DIV) |-> (r_q[NST] != TICKS_MAX))
        else $error("quotient overflow");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_v[NST] && r_k[NST] == K_ZERO) |=> (r_ot == '0))
        else $error("zero interval gave ticks");

endmodule

@@ design/time_interval_to_ticks_unit.sv @@
// Top level of the time interval to ticks converter.
//
// Input channel: i_valid / o_stall carry i_operation, i_seconds and i_fraction;
// a transfer happens at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry o_ticks, one result per input.
// Config channel: i_cfg_valid / o_cfg_ready write the tick length in
// microseconds from i_cfg_data; o_cfg_ready is always high. Write it only
// while no conversion is in flight.
// Throughput: one item per cycle while i_stall is low. An input transfer
// reaches o_valid through two front stages, the queue, three scaling stages
// and one restoring divider stage per quotient bit plus the output register.
// Reset (synchronous, i_rst_n low) empties every stage and the queue and
// loads a tick length of 10000 us.
// A stalled result holds the whole divider pipeline; the queue then fills
// and o_stall rises once it is full.
module time_interval_to_ticks_unit import tit_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [TICK_W-1:0]  i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_operation,
    input  logic [SEC_W-1:0]   i_seconds,
    input  logic [FRAC_W-1:0]  i_fraction,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [TICKS_W-1:0] o_ticks
);

    logic [TICK_W-1:0] r_tick;
    logic              push, pop, empty, full;
    t_job              f_job, q_job;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= TICK_RESET;
        end else if (i_cfg_valid) begin
            r_tick <= i_cfg_data;
        end
    end

    tit_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (!full),
        .i_tick      (r_tick),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_seconds   (i_seconds),
        .i_fraction  (i_fraction),
        .o_push      (push),
        .o_job       (f_job)
    );

    tit_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_empty (empty),
        .o_full  (full),
        .o_job   (q_job)
    );

    tit_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (r_tick),
        .i_empty (empty),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_ticks (o_ticks)
    );

endmodule

@@ tb/sv/time_interval_to_ticks_unit_tb.sv @@
// Self-checking testbench for the time interval to ticks converter.
`timescale 1ns / 100ps

module time_interval_to_ticks_unit_tb import tit_pkg::*;;

    localparam logic OP_USEC = 1'b0;
    localparam logic OP_NSEC = 1'b1;
    localparam longint unsigned CYCLE_LIMIT = 64'd2000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [TICK_W-1:0]  i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_operation = 1'b0;
    logic [SEC_W-1:0]   i_seconds = '0;
    logic [FRAC_W-1:0]  i_fraction = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [TICKS_W-1:0] o_ticks;

    logic [TICK_W-1:0]  tick_len;
    logic [TICKS_W-1:0] expected_ticks[$];
    int                 mismatches = 0;
    int                 items_sent = 0;
    int                 results_seen = 0;
    longint unsigned    cycle_count = 0;
    bit                 sender_busy_mode = 1'b1;
    bit                 receiver_busy_mode = 1'b1;

    time_interval_to_ticks_unit u_top (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [TICKS_W-1:0] interval_to_ticks(logic op, logic [63:0] secs,
                                                              logic [29:0] frac);
        logic signed [64:0] sec_ext;
        logic [63:0]        usec;
        logic [127:0]       total;
        logic [127:0]       quot;
        sec_ext = {secs[63], secs};
        if (op == OP_USEC) begin
            usec = frac;
        end else begin
            usec = frac / 1000;
            if (frac % 1000 != 0) begin
                usec += 1;
                if (usec >= 1000000) begin
                    usec -= 1000000;
                    sec_ext += 1;
                end
            end
        end
        if (sec_ext < 0 || (sec_ext == 0 && usec == 0)) return '0;
        if (sec_ext > 65'sd9223372036854 || tick_len == 0) return TICKS_MAX;
        total = 128'(sec_ext) * 1000000 + usec + (tick_len - 1);
        quot = total / tick_len + 1;
        return (quot > TICKS_MAX) ? TICKS_MAX : quot[TICKS_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, want %0d", what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // result checker and random output stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_ticks.size() == 0) begin
                report_mismatch("unexpected result", o_ticks, -1);
            end else begin
                logic [TICKS_W-1:0] want;
                want = expected_ticks.pop_front();
                if (o_ticks !== want) report_mismatch("ticks", o_ticks, want);
            end
        end
        i_stall <= receiver_busy_mode ? ($urandom_range(99) < 20) : 1'b0;
    end

    task automatic send_item(input logic op, input logic [63:0] secs, input logic [29:0] frac);
        while (sender_busy_mode && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_seconds   <= secs;
        i_fraction  <= frac;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_ticks.push_back(interval_to_ticks(op, secs, frac));
        items_sent++;
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic write_tick_len(input logic [TICK_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tick_len = value;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] random_seconds();
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(20));
            2: return -64'($urandom_range(3));
            3: return 64'd9223372036854 + 64'($urandom_range(2)) - 1;
            default: return 64'($urandom_range(100000));
        endcase
    endfunction

    function automatic logic [29:0] random_fraction();
        case ($urandom_range(4))
            0: return 30'($urandom);
            1: return 30'd999999000 + 30'($urandom_range(999));
            2: return 30'($urandom_range(999999));
            3: return 30'($urandom_range(3));
            default: return 30'($urandom_range(999999999));
        endcase
    endfunction

    task automatic test_reset_divisor;
        send_item(OP_USEC, 64'd1, 30'd0);
        send_item(OP_USEC, 64'd0, 30'd1);
        send_item(OP_NSEC, 64'd0, 30'd1);
    endtask

    task automatic test_directed_edges;
        send_item(OP_USEC, 64'd0, 30'd0);
        send_item(OP_NSEC, 64'd0, 30'd0);
        send_item(OP_USEC, SEC_MAX, 30'd0);
        send_item(OP_USEC, {1'b1, 63'd0}, 30'd5);
        send_item(OP_USEC, '1, 30'd999999);
        send_item(OP_NSEC, '1, 30'd999999999);
        send_item(OP_NSEC, SEC_MAX, 30'd999999001);
        send_item(OP_NSEC, 64'd5, 30'd999999999);
        send_item(OP_NSEC, 64'd5, 30'd999999000);
        send_item(OP_NSEC, 64'd0, '1);
        send_item(OP_USEC, 64'd0, '1);
        send_item(OP_USEC, 64'd9223372036854, 30'd0);
        send_item(OP_USEC, 64'd9223372036855, 30'd0);
        send_item(OP_USEC, 64'd2147, 30'd483647);
        send_item(OP_USEC, 64'h5555_5555_5555_5555, 30'h2aaa_aaaa);
        send_item(OP_NSEC, 64'haaaa_aaaa_aaaa_aaaa, 30'h1555_5555);
    endtask

    task automatic test_divisor_extremes;
        write_tick_len(20'd1);
        test_directed_edges();
        write_tick_len(20'd0);
        send_item(OP_USEC, 64'd0, 30'd1);
        send_item(OP_USEC, 64'd0, 30'd0);
        send_item(OP_USEC, -64'd1, 30'd0);
        write_tick_len('1);
        test_directed_edges();
        write_tick_len(20'd1000000);
        test_directed_edges();
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (n == count / 3) begin
                sender_busy_mode = 1'b0;
                receiver_busy_mode = 1'b0;
            end
            if (n == count / 2) begin
                sender_busy_mode = 1'b1;
                receiver_busy_mode = 1'b1;
            end
            send_item(1'($urandom), random_seconds(), random_fraction());
        end
    endtask

    initial begin
        tick_len = TICK_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_divisor();
        test_directed_edges();
        test_divisor_extremes();
        write_tick_len(20'($urandom_range(1, 1000)));
        test_random(400);
        write_tick_len(20'($urandom_range(1, 1048575)));
        test_random(400);
        write_tick_len(TICK_RESET);
        test_random(380);
        drain();
        $display("Covered %0d conversions, %0d results, both fraction units,", items_sent,
                 results_seen);
        $display("tick lengths 0, 1, 10000, 1000000, max and random, with stalls on both sides.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
